// ===== rtl/nal_unit_start_code_splitter_assert.svh =====
// Assertion macros for the start code splitter.
// Each use expects clk and rst_n in scope.
`ifndef NAL_UNIT_START_CODE_SPLITTER_ASSERT_SVH
`define NAL_UNIT_START_CODE_SPLITTER_ASSERT_SVH
`ifndef SYNTH
`define NSCS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define NSCS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define NSCS_ASSERT_IMP(lbl, ante, cons, msg)
`define NSCS_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/nscs_pkg.sv =====
`default_nettype none

package nscs_pkg;

    localparam int MaxRes = 5;
    localparam int CntW   = $clog2(MaxRes + 1);
    localparam int QDepth = 2;
    localparam int QPtrW  = $clog2(QDepth);
    localparam int QCntW  = $clog2(QDepth + 1);

    localparam logic [7:0] Mask264 = 8'h1F;
    localparam logic [7:0] Mask265 = 8'h7E;

    localparam logic CfgCodecMode  = 1'b0;
    localparam logic CfgKeepMarker = 1'b1;

    typedef struct packed {
        logic       byte_valid;
        logic [7:0] out_byte;
        logic       unit_start;
        logic       unit_end;
        logic [5:0] unit_type;
    } res_t;

    // all results caused by one input byte
    typedef struct packed {
        res_t [MaxRes-1:0] res;
        logic [CntW-1:0]   count;
        logic              buffer_done;
        logic              no_start_code;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic nonempty;
    } qstat_t;

    function automatic res_t mk_res(logic vld, logic [7:0] data, logic first,
                                    logic last, logic [5:0] kind);
        res_t r;
        r.byte_valid = vld;
        r.out_byte   = data;
        r.unit_start = first;
        r.unit_end   = last;
        r.unit_type  = kind;
        return r;
    endfunction

    function automatic cmd_t append(cmd_t c, res_t r);
        cmd_t o;
        o = c;
        if (c.count < CntW'(MaxRes))
        begin
            o.res[c.count] = r;
            o.count        = c.count + CntW'(1);
        end
        return o;
    endfunction

    function automatic logic [5:0] hdr_type(logic [7:0] b, logic mode);
        logic [7:0] t;
        if (mode)
        begin
            t = (b & Mask265) >> 1;
        end
        else
        begin
            t = b & Mask264;
        end
        return t[5:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/nscs_front.sv =====
`default_nettype none

module nscs_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_valid,
    input  wire logic             cfg_index,
    input  wire logic             cfg_data,
    output logic                  cfg_ready,
    input  wire logic             item_valid,
    input  wire logic [7:0]       data_byte,
    input  wire logic             end_of_buffer,
    output logic                  item_stall,
    input  wire nscs_pkg::qstat_t q_stat,
    output logic                  q_push,
    output nscs_pkg::cmd_t        q_entry
);

    localparam logic [2:0] HeldDepth = 3'd4;

    logic       codec_mode_reg;
    logic       keep_marker_reg;

    // held bytes: only the first can be nonzero, the rest are zeros
    logic [7:0] h0_reg, h0_next;
    logic [2:0] hc_reg, hc_next;
    logic [1:0] zr_reg, zr_next;
    logic       in_unit_reg, in_unit_next;
    logic       await_reg, await_next;
    logic       long_reg, long_next;
    logic [5:0] type_reg, type_next;
    logic [1:0] bcnt_reg, bcnt_next;
    logic       seen_reg, seen_next;
    logic       started_reg, started_next;
    logic       accept;

    assign cfg_ready  = 1'b1;
    assign item_stall = q_stat.full;
    assign accept     = item_valid && !q_stat.full;
    assign q_push     = accept && (q_entry.count != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            codec_mode_reg  <= 1'b0;
            keep_marker_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == nscs_pkg::CfgCodecMode)
            begin
                codec_mode_reg <= cfg_data;
            end
            else if (cfg_index == nscs_pkg::CfgKeepMarker)
            begin
                keep_marker_reg <= cfg_data;
            end
        end
    end

    always_comb
    begin
        h0_next      = h0_reg;
        hc_next      = hc_reg;
        zr_next      = zr_reg;
        in_unit_next = in_unit_reg;
        await_next   = await_reg;
        long_next    = long_reg;
        type_next    = type_reg;
        bcnt_next    = bcnt_reg;
        seen_next    = seen_reg;
        started_next = started_reg;
        q_entry      = '0;

        if (bcnt_next != 2'd3)
        begin
            bcnt_next = bcnt_next + 2'd1;
        end

        if (!in_unit_reg)
        begin
            // hunting for the first start code of the buffer
            if (data_byte == 8'h00)
            begin
                if (zr_next != 2'd3)
                begin
                    zr_next = zr_next + 2'd1;
                end
            end
            else if (data_byte == 8'h01 && zr_next[1])
            begin
                long_next    = (zr_next == 2'd3);
                zr_next      = '0;
                hc_next      = '0;
                in_unit_next = 1'b1;
                await_next   = 1'b1;
                started_next = 1'b0;
                seen_next    = 1'b1;
            end
            else
            begin
                zr_next = '0;
            end
        end
        else
        begin
            if (await_reg)
            begin
                type_next  = nscs_pkg::hdr_type(data_byte, codec_mode_reg);
                await_next = 1'b0;
                if (keep_marker_reg)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        if (i < 2 || long_next)
                        begin
                            q_entry = nscs_pkg::append(q_entry, nscs_pkg::mk_res(
                                1'b1, 8'h00, !started_next, 1'b0, type_next));
                            started_next = 1'b1;
                        end
                    end
                    h0_next = 8'h01;
                    hc_next = 3'd1;
                    zr_next = '0;
                end
            end

            if (data_byte == 8'h00)
            begin
                if (zr_next != 2'd3)
                begin
                    if (hc_next != HeldDepth)
                    begin
                        if (hc_next == 3'd0)
                        begin
                            h0_next = 8'h00;
                        end
                        hc_next = hc_next + 3'd1;
                    end
                    zr_next = zr_next + 2'd1;
                end
                else
                begin
                    // more than three zeros: the oldest one is unit data
                    if (hc_next > {1'b0, zr_next} && hc_next != 3'd0)
                    begin
                        q_entry = nscs_pkg::append(q_entry, nscs_pkg::mk_res(
                            1'b1, h0_next, !started_next, 1'b0, type_next));
                        started_next = 1'b1;
                        h0_next      = 8'h00;
                        hc_next      = hc_next - 3'd1;
                    end
                    if (hc_next != HeldDepth)
                    begin
                        if (hc_next == 3'd0)
                        begin
                            h0_next = 8'h00;
                        end
                        hc_next = hc_next + 3'd1;
                    end
                end
            end
            else if (data_byte == 8'h01 && zr_next[1])
            begin
                if (hc_next > {1'b0, zr_next})
                begin
                    q_entry = nscs_pkg::append(q_entry, nscs_pkg::mk_res(
                        1'b1, h0_next, !started_next, 1'b1, type_next));
                end
                else
                begin
                    q_entry = nscs_pkg::append(q_entry, nscs_pkg::mk_res(
                        1'b0, 8'h00, !started_next, 1'b1, type_next));
                end
                long_next    = (zr_next == 2'd3);
                zr_next      = '0;
                hc_next      = '0;
                in_unit_next = 1'b1;
                await_next   = 1'b1;
                started_next = 1'b0;
                seen_next    = 1'b1;
            end
            else
            begin
                for (int i = 0; i < 4; i++)
                begin
                    if (3'(i) < hc_next)
                    begin
                        q_entry = nscs_pkg::append(q_entry, nscs_pkg::mk_res(
                            1'b1, (i == 0) ? h0_next : 8'h00, !started_next, 1'b0,
                            type_next));
                        started_next = 1'b1;
                    end
                end
                h0_next = data_byte;
                hc_next = 3'd1;
                zr_next = '0;
            end
        end

        if (end_of_buffer)
        begin
            if (in_unit_next)
            begin
                if (await_next)
                begin
                    // start code on the last byte: no header, type 0
                    type_next = '0;
                    if (keep_marker_reg)
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            if (i < 2 || long_next)
                            begin
                                q_entry = nscs_pkg::append(q_entry, nscs_pkg::mk_res(
                                    1'b1, 8'h00, !started_next, 1'b0, type_next));
                                started_next = 1'b1;
                            end
                        end
                        q_entry = nscs_pkg::append(q_entry, nscs_pkg::mk_res(
                            1'b1, 8'h01, !started_next, 1'b1, type_next));
                    end
                    else
                    begin
                        q_entry = nscs_pkg::append(q_entry, nscs_pkg::mk_res(
                            1'b0, 8'h00, 1'b1, 1'b1, type_next));
                    end
                end
                else if (hc_next != 3'd0)
                begin
                    for (int i = 0; i < 4; i++)
                    begin
                        if (3'(i) < hc_next)
                        begin
                            q_entry = nscs_pkg::append(q_entry, nscs_pkg::mk_res(
                                1'b1, (i == 0) ? h0_next : 8'h00, !started_next,
                                (3'(i) + 3'd1 == hc_next), type_next));
                            started_next = 1'b1;
                        end
                    end
                end
                else
                begin
                    q_entry = nscs_pkg::append(q_entry, nscs_pkg::mk_res(
                        1'b0, 8'h00, !started_next, 1'b1, type_next));
                end
            end
            if (q_entry.count == '0)
            begin
                q_entry = nscs_pkg::append(q_entry, nscs_pkg::mk_res(
                    1'b0, 8'h00, 1'b0, 1'b0, 6'd0));
            end
            q_entry.buffer_done   = 1'b1;
            q_entry.no_start_code = (bcnt_next == 2'd3) && !seen_next;

            h0_next      = '0;
            hc_next      = '0;
            zr_next      = '0;
            in_unit_next = 1'b0;
            await_next   = 1'b0;
            long_next    = 1'b0;
            type_next    = '0;
            bcnt_next    = '0;
            seen_next    = 1'b0;
            started_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h0_reg      <= '0;
            hc_reg      <= '0;
            zr_reg      <= '0;
            in_unit_reg <= 1'b0;
            await_reg   <= 1'b0;
            long_reg    <= 1'b0;
            type_reg    <= '0;
            bcnt_reg    <= '0;
            seen_reg    <= 1'b0;
            started_reg <= 1'b0;
        end
        else if (accept)
        begin
            h0_reg      <= h0_next;
            hc_reg      <= hc_next;
            zr_reg      <= zr_next;
            in_unit_reg <= in_unit_next;
            await_reg   <= await_next;
            long_reg    <= long_next;
            type_reg    <= type_next;
            bcnt_reg    <= bcnt_next;
            seen_reg    <= seen_next;
            started_reg <= started_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/nscs_queue.sv =====
`default_nettype none

module nscs_queue (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire nscs_pkg::cmd_t   entry,
    input  wire logic             pop,
    output nscs_pkg::cmd_t        head,
    output nscs_pkg::qstat_t      q_stat
);

    localparam int PtrW  = nscs_pkg::QPtrW;
    localparam int CntW  = nscs_pkg::QCntW;
    localparam int Depth = nscs_pkg::QDepth;

    nscs_pkg::cmd_t  slots [Depth];
    logic [PtrW-1:0] wr_ptr_reg;
    logic [PtrW-1:0] rd_ptr_reg;
    logic [CntW-1:0] cnt_reg;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_ptr_reg] <= entry;
        end
    end

    assign head            = slots[rd_ptr_reg];
    assign q_stat.full     = (cnt_reg == CntW'(Depth));
    assign q_stat.nonempty = (cnt_reg != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PtrW'(Depth - 1)) ? '0 : wr_ptr_reg + PtrW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PtrW'(Depth - 1)) ? '0 : rd_ptr_reg + PtrW'(1);
            end
            unique case ({push, pop})
                2'b10:   cnt_reg <= cnt_reg + CntW'(1);
                2'b01:   cnt_reg <= cnt_reg - CntW'(1);
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== rtl/nscs_back.sv =====
`default_nettype none

module nscs_back (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire nscs_pkg::cmd_t   head,
    input  wire nscs_pkg::qstat_t q_stat,
    output logic                  pop,
    output logic                  result_valid,
    input  wire logic             result_stall,
    output logic                  byte_valid,
    output logic [7:0]            out_byte,
    output logic                  unit_start,
    output logic                  unit_end,
    output logic [5:0]            unit_type,
    output logic                  buffer_done,
    output logic                  no_start_code,
    output logic                  last_of_run
);

    localparam int CntW = nscs_pkg::CntW;

    logic [CntW-1:0]      idx_reg;
    logic                 valid_reg;
    nscs_pkg::res_t       res_reg;
    logic                 done_reg;
    logic                 nsc_reg;
    logic                 last_reg;
    logic                 load;
    logic                 take;
    logic                 last;

    // output register loads whenever it is empty or being drained
    assign load = !valid_reg || !result_stall;
    assign take = load && q_stat.nonempty;
    assign last = (idx_reg == head.count - CntW'(1));
    assign pop  = take && last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            if (load)
            begin
                valid_reg <= q_stat.nonempty;
            end
            if (take)
            begin
                idx_reg <= last ? '0 : idx_reg + CntW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            res_reg  <= head.res[idx_reg];
            done_reg <= last && head.buffer_done;
            nsc_reg  <= last && head.no_start_code;
            last_reg <= last;
        end
    end

    assign result_valid  = valid_reg;
    assign byte_valid    = res_reg.byte_valid;
    assign out_byte      = res_reg.out_byte;
    assign unit_start    = res_reg.unit_start;
    assign unit_end      = res_reg.unit_end;
    assign unit_type     = res_reg.unit_type;
    assign buffer_done   = done_reg;
    assign no_start_code = nsc_reg;
    assign last_of_run   = last_reg;

endmodule

`default_nettype wire

// ===== rtl/nal_unit_start_code_splitter.sv =====
// Annex B NAL unit splitter. Bytes enter on the item channel one per beat,
// end_of_buffer on the last byte of a capture buffer; each unit leaves on the
// result channel with start/end/type tags, marker bytes kept or stripped per
// keep_marker, and unit type taken from the H.264 or H.265 header per
// codec_mode. A byte is classified combinationally by the front end, which puts
// all of its results (zero to five) as one entry into a two-entry queue; the
// back end sends one result per cycle from the queue head through an output
// register while result_stall is low. Sustained rate is one byte per cycle
// while bytes give at most one result each and result_stall is low; a byte
// with k results holds the back end until all k are sent, and the front end
// stalls only when both queue entries are taken. The first result of a byte
// passes through a queue slot and then the output register on its way to the
// result port. cfg_ready is always high; write the registers only while the
// block is idle. No clearing pass after reset.
`default_nettype none
`include "nal_unit_start_code_splitter_assert.svh"

module nal_unit_start_code_splitter (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic       cfg_index,
    input  wire logic       cfg_data,
    input  wire logic       item_valid,
    output logic            item_stall,
    input  wire logic [7:0] data_byte,
    input  wire logic       end_of_buffer,
    output logic            result_valid,
    input  wire logic       result_stall,
    output logic            byte_valid,
    output logic [7:0]      out_byte,
    output logic            unit_start,
    output logic            unit_end,
    output logic [5:0]      unit_type,
    output logic            buffer_done,
    output logic            no_start_code,
    output logic            last_of_run
);

    nscs_pkg::cmd_t   q_entry;
    nscs_pkg::cmd_t   q_head;
    nscs_pkg::qstat_t q_stat;
    logic             q_push;
    logic             q_pop;

    nscs_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .cfg_ready     (cfg_ready),
        .item_valid    (item_valid),
        .data_byte     (data_byte),
        .end_of_buffer (end_of_buffer),
        .item_stall    (item_stall),
        .q_stat        (q_stat),
        .q_push        (q_push),
        .q_entry       (q_entry)
    );

    nscs_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (q_push),
        .entry  (q_entry),
        .pop    (q_pop),
        .head   (q_head),
        .q_stat (q_stat)
    );

    nscs_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (q_head),
        .q_stat        (q_stat),
        .pop           (q_pop),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .byte_valid    (byte_valid),
        .out_byte      (out_byte),
        .unit_start    (unit_start),
        .unit_end      (unit_end),
        .unit_type     (unit_type),
        .buffer_done   (buffer_done),
        .no_start_code (no_start_code),
        .last_of_run   (last_of_run)
    );

    `NSCS_ASSERT_IMP(a_done_is_last, result_valid && buffer_done, last_of_run, "buffer_done not on last beat of a byte")
    `NSCS_ASSERT_IMP(a_nsc_with_done, result_valid && no_start_code, buffer_done, "no_start_code without buffer_done")
    `NSCS_ASSERT_IMP(a_status_byte_zero, result_valid && !byte_valid, out_byte == 8'h00, "status beat carries a byte")
    `NSCS_ASSERT_IMP(a_head_not_empty, q_stat.nonempty, q_head.count != '0, "queue holds an entry with no results")
    `NSCS_ASSERT_NXT(a_push_lands, q_push, q_stat.nonempty, "pushed entry lost from queue")

endmodule

`default_nettype wire
